>>> rtl/kdns_pkg.sv
package kdns_pkg;

  localparam int unsigned CompW   = 8;
  localparam int unsigned PointW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned DimW    = 7;
  localparam int unsigned DimsW   = 8;
  localparam int unsigned S1W     = 14;
  localparam int unsigned S2W     = 22;
  localparam int unsigned SqW     = 28;
  localparam int unsigned VarW    = 29;
  localparam int unsigned OutDataW = 40;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_DIMS_IN_USE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VAR_RD,
    ST_VAR_ACC,
    ST_VAR_MUL,
    ST_VAR_CMP,
    ST_VAR_DONE,
    ST_MED_RD,
    ST_MED_CHK,
    ST_MED_DEC,
    ST_ORD_INIT,
    ST_PART_RD,
    ST_PART_CHK,
    ST_PART_WR2,
    ST_SWAP_RA,
    ST_SWAP_RB,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_OUT_RD,
    ST_OUT_SEND
  } state_e;

  typedef struct packed {
    logic clr_best;
    logic clr_acc;
    logic acc;
    logic mul;
    logic cmp;
  } var_ctrl_t;

endpackage

>>> rtl/kd_tree_node_split.sv
// kd-tree node splitter. Components stream in point-major order on s_axis,
// one per cycle, into a descriptor RAM; tlast marks the final component and
// starts the split, during which s_axis_tready stays low. The split picks the
// dimension of greatest variance (each dimension accumulated over all points,
// then scored; winner latched), finds the lower median by an 8-pass radix
// select over that dimension, partitions an order RAM (initialize, read and
// check each point, second write per point going left, swap the median to the
// boundary) and streams n results on m_axis as the sink accepts them. The
// variance, median and partition steps are paced by the single read port of
// the descriptor RAM. Results: tdata = {left_count, split_value, split_dim,
// point_index, position}, tuser = is_leaf, tlast = last result.
module kd_tree_node_split #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned MAX_DIMS   = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] component_value
  input  logic        s_axis_tlast,   // set_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] position, [11:6] point_index, [18:12] split_dim,
  // [26:19] split_value, [33:27] left_count, [39:34] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,   // is_leaf
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned Depth = MAX_POINTS * MAX_DIMS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned OAW   = $clog2(MAX_POINTS);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  kdns_pkg::state_e state_q, state_d;

  logic [6:0]    pc_q;
  logic [7:0]    dims_q;
  logic [6:0]    n_q;
  logic [7:0]    d_q;
  logic [AW-1:0] load_cnt_q;
  logic [AW-1:0] addr_q;
  logic [5:0]    i_q;
  logic [6:0]    dim_q;
  logic [7:0]    mask_q, bsel_q, pfx_q;
  logic [5:0]    rank_q;
  logic [6:0]    cnt_q;
  logic [6:0]    jn_q;
  logic [5:0]    p_q, t_q, a_q, k_q;

  logic          in_fire, out_fire;
  logic [7:0]    x;
  logic          last_i, last_dim, med_hit;
  logic [6:0]    n_cl;
  logic [7:0]    d_cl;
  logic [AW-1:0] addr_step;
  logic [AW-1:0] ki_addr;
  logic [6:0]    cnt_nx;
  logic [6:0]    split_dim;

  kdns_pkg::var_ctrl_t var_ctrl;

  logic           ord_we;
  logic [OAW-1:0] ord_waddr, ord_raddr;
  logic [5:0]     ord_wdata, ord_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign n_cl = (pc_q == 7'd0) ? 7'd1 : ((pc_q > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : pc_q);
  assign d_cl = (dims_q == 8'd0) ? 8'd1 : ((dims_q > 8'(MAX_DIMS)) ? 8'(MAX_DIMS) : dims_q);

  assign last_i    = ({1'b0, i_q} == (n_q - 7'd1));
  assign last_dim  = ({1'b0, dim_q} == (d_q - 8'd1));
  assign addr_step = addr_q + AW'(d_q);
  assign ki_addr   = AW'(split_dim);
  assign med_hit   = (((x ^ pfx_q) & mask_q) == 8'd0) && ((x & bsel_q) == 8'd0);
  assign cnt_nx    = cnt_q + {6'd0, med_hit};

  kdns_ram #(.Width(8), .Depth(Depth)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_cnt_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (addr_q),
    .rdata_o (x)
  );

  kdns_ram #(.Width(6), .Depth(MAX_POINTS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  kdns_var_unit u_var (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (var_ctrl),
    .x_i         (x),
    .n_i         (n_q),
    .dim_i       (dim_q),
    .split_dim_o (split_dim)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kdns_pkg::ST_IDLE:     if (in_fire && s_axis_tlast) state_d = kdns_pkg::ST_VAR_RD;
      kdns_pkg::ST_VAR_RD:   state_d = kdns_pkg::ST_VAR_ACC;
      kdns_pkg::ST_VAR_ACC:  state_d = last_i ? kdns_pkg::ST_VAR_MUL : kdns_pkg::ST_VAR_RD;
      kdns_pkg::ST_VAR_MUL:  state_d = kdns_pkg::ST_VAR_CMP;
      kdns_pkg::ST_VAR_CMP:  state_d = last_dim ? kdns_pkg::ST_VAR_DONE : kdns_pkg::ST_VAR_RD;
      kdns_pkg::ST_VAR_DONE: state_d = kdns_pkg::ST_MED_RD;
      kdns_pkg::ST_MED_RD:   state_d = kdns_pkg::ST_MED_CHK;
      kdns_pkg::ST_MED_CHK:  state_d = last_i ? kdns_pkg::ST_MED_DEC : kdns_pkg::ST_MED_RD;
      kdns_pkg::ST_MED_DEC:  state_d = bsel_q[0] ? kdns_pkg::ST_ORD_INIT : kdns_pkg::ST_MED_RD;
      kdns_pkg::ST_ORD_INIT: state_d = last_i ? kdns_pkg::ST_PART_RD : kdns_pkg::ST_ORD_INIT;
      kdns_pkg::ST_PART_RD:  state_d = kdns_pkg::ST_PART_CHK;
      kdns_pkg::ST_PART_CHK: begin
        if (x <= pfx_q) state_d = kdns_pkg::ST_PART_WR2;
        else state_d = last_i ? kdns_pkg::ST_SWAP_RA : kdns_pkg::ST_PART_RD;
      end
      kdns_pkg::ST_PART_WR2: state_d = last_i ? kdns_pkg::ST_SWAP_RA : kdns_pkg::ST_PART_RD;
      kdns_pkg::ST_SWAP_RA:  state_d = kdns_pkg::ST_SWAP_RB;
      kdns_pkg::ST_SWAP_RB:  state_d = kdns_pkg::ST_SWAP_WA;
      kdns_pkg::ST_SWAP_WA:  state_d = kdns_pkg::ST_SWAP_WB;
      kdns_pkg::ST_SWAP_WB:  state_d = kdns_pkg::ST_OUT_RD;
      kdns_pkg::ST_OUT_RD:   state_d = kdns_pkg::ST_OUT_SEND;
      kdns_pkg::ST_OUT_SEND: begin
        if (out_fire) begin
          state_d = ({1'b0, k_q} == (n_q - 7'd1)) ? kdns_pkg::ST_IDLE : kdns_pkg::ST_OUT_RD;
        end
      end
      default:               state_d = kdns_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    var_ctrl      = '0;
    ord_we        = 1'b0;
    ord_waddr     = OAW'(i_q);
    ord_wdata     = i_q;
    ord_raddr     = OAW'(k_q);
    case (state_q)
      kdns_pkg::ST_IDLE: begin
        s_axis_tready    = 1'b1;
        var_ctrl.clr_acc  = 1'b1;
        var_ctrl.clr_best = 1'b1;
      end
      kdns_pkg::ST_VAR_ACC:  var_ctrl.acc = 1'b1;
      kdns_pkg::ST_VAR_MUL:  var_ctrl.mul = 1'b1;
      kdns_pkg::ST_VAR_CMP: begin
        var_ctrl.cmp     = 1'b1;
        var_ctrl.clr_acc = 1'b1;
      end
      kdns_pkg::ST_ORD_INIT: ord_we = 1'b1;
      kdns_pkg::ST_PART_RD:  ord_raddr = OAW'(jn_q);
      kdns_pkg::ST_PART_CHK: begin
        ord_raddr = OAW'(jn_q);
        ord_we    = (x <= pfx_q);
        ord_waddr = OAW'(jn_q);
        ord_wdata = i_q;
      end
      kdns_pkg::ST_PART_WR2: begin
        ord_we    = 1'b1;
        ord_waddr = OAW'(i_q);
        ord_wdata = t_q;
      end
      kdns_pkg::ST_SWAP_RA:  ord_raddr = OAW'(p_q);
      kdns_pkg::ST_SWAP_RB:  ord_raddr = OAW'(jn_q - 7'd1);
      kdns_pkg::ST_SWAP_WA: begin
        ord_raddr = OAW'(jn_q - 7'd1);
        ord_we    = 1'b1;
        ord_waddr = OAW'(p_q);
        ord_wdata = ord_rdata;
      end
      kdns_pkg::ST_SWAP_WB: begin
        ord_we    = 1'b1;
        ord_waddr = OAW'(jn_q - 7'd1);
        ord_wdata = a_q;
      end
      kdns_pkg::ST_OUT_SEND: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kdns_pkg::ST_IDLE;
      pc_q       <= 7'd64;
      dims_q     <= 8'd128;
      load_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == kdns_pkg::REG_POINT_COUNT) pc_q <= cfg_data_i[6:0];
        else if (cfg_index_i == kdns_pkg::REG_DIMS_IN_USE) dims_q <= cfg_data_i;
      end
      if (in_fire) begin
        if (s_axis_tlast || (load_cnt_q == LastAddr)) load_cnt_q <= '0;
        else load_cnt_q <= load_cnt_q + AW'(1);
      end
    end
  end

  // datapath sequencing
  always_ff @(posedge clk_i) begin
    case (state_q)
      kdns_pkg::ST_IDLE: begin
        n_q    <= n_cl;
        d_q    <= d_cl;
        i_q    <= '0;
        dim_q  <= '0;
        addr_q <= '0;
      end
      kdns_pkg::ST_VAR_ACC: begin
        if (!last_i) begin
          i_q    <= i_q + 6'd1;
          addr_q <= addr_step;
        end
      end
      kdns_pkg::ST_VAR_CMP: begin
        i_q <= '0;
        if (last_dim) begin
          // median search setup
          mask_q <= '0;
          bsel_q <= 8'h80;
          pfx_q  <= '0;
          rank_q <= 6'((n_q - 7'd1) >> 1);
          cnt_q  <= '0;
        end else begin
          dim_q  <= dim_q + 7'd1;
          addr_q <= AW'(dim_q + 7'd1);
        end
      end
      // the winner settled on the last compare edge
      kdns_pkg::ST_VAR_DONE: addr_q <= ki_addr;
      kdns_pkg::ST_MED_CHK: begin
        cnt_q <= cnt_nx;
        if (!last_i) begin
          i_q    <= i_q + 6'd1;
          addr_q <= addr_step;
        end
      end
      kdns_pkg::ST_MED_DEC: begin
        if ({1'b0, rank_q} >= cnt_q) begin
          pfx_q  <= pfx_q | bsel_q;
          rank_q <= rank_q - 6'(cnt_q);
        end
        mask_q <= mask_q | bsel_q;
        bsel_q <= bsel_q >> 1;
        cnt_q  <= '0;
        i_q    <= '0;
        addr_q <= ki_addr;
        jn_q   <= '0;
        p_q    <= '0;
      end
      kdns_pkg::ST_ORD_INIT: begin
        if (last_i) i_q <= '0;
        else i_q <= i_q + 6'd1;
      end
      kdns_pkg::ST_PART_CHK: begin
        if (x <= pfx_q) begin
          t_q <= ord_rdata;
          if (x == pfx_q) p_q <= 6'(jn_q);
        end else if (!last_i) begin
          i_q    <= i_q + 6'd1;
          addr_q <= addr_step;
        end
      end
      kdns_pkg::ST_PART_WR2: begin
        jn_q <= jn_q + 7'd1;
        if (!last_i) begin
          i_q    <= i_q + 6'd1;
          addr_q <= addr_step;
        end
      end
      kdns_pkg::ST_SWAP_RB: a_q <= ord_rdata;
      kdns_pkg::ST_SWAP_WB: k_q <= '0;
      kdns_pkg::ST_OUT_SEND: if (out_fire) k_q <= k_q + 6'd1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {6'd0, jn_q, pfx_q, split_dim, ord_rdata, k_q};
  assign m_axis_tuser = (n_q <= 7'd1) || (jn_q == n_q);
  assign m_axis_tlast = ({1'b0, k_q} == (n_q - 7'd1));

endmodule

>>> rtl/kdns_ram.sv
module kdns_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kdns_var_unit.sv
// Accumulates sum(x) and sum(x^2) of one dimension, then scores it as
// n*sum(x^2) - sum(x)^2 and keeps the first dimension with the largest score.
module kdns_var_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kdns_pkg::var_ctrl_t               ctrl_i,
  input  logic [kdns_pkg::CompW-1:0]        x_i,
  input  logic [kdns_pkg::CountW-1:0]       n_i,
  input  logic [kdns_pkg::DimW-1:0]         dim_i,
  output logic [kdns_pkg::DimW-1:0]         split_dim_o
);

  logic [kdns_pkg::S1W-1:0]  s1_q;
  logic [kdns_pkg::S2W-1:0]  s2_q;
  logic [kdns_pkg::VarW-1:0] ns2_q;
  logic [kdns_pkg::SqW-1:0]  sq_q;
  logic [kdns_pkg::VarW-1:0] best_q;
  logic [kdns_pkg::DimW-1:0] ki_q;
  logic [15:0]               xx;
  logic [kdns_pkg::VarW-1:0] score;

  assign xx    = x_i * x_i;
  assign score = ns2_q - {1'b0, sq_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_acc) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (ctrl_i.acc) begin
      s1_q <= s1_q + kdns_pkg::S1W'(x_i);
      s2_q <= s2_q + kdns_pkg::S2W'(xx);
    end
    if (ctrl_i.mul) begin
      ns2_q <= kdns_pkg::VarW'(n_i) * kdns_pkg::VarW'(s2_q);
      sq_q  <= kdns_pkg::SqW'(s1_q) * kdns_pkg::SqW'(s1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      ki_q   <= '0;
    end else if (ctrl_i.clr_best) begin
      best_q <= '0;
      ki_q   <= '0;
    end else if (ctrl_i.cmp && (score > best_q)) begin
      best_q <= score;
      ki_q   <= dim_i;
    end
  end

  assign split_dim_o = ki_q;

endmodule
